// ===== hdl/isma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isma_pkg
// Shared types and constants of the masked image-stack accumulator.
// ----------------------------------------------------------------------------
package isma_pkg;

    localparam int CMD_W     = 2;
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 10;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int DIM_W     = 11;

    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEAK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SUM_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

    localparam logic             RST_SUM_MODE  = 1'b1;
    localparam logic [PIX_W-1:0] RST_THRESHOLD = 16'd400;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 11'd1024;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 11'd1024;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic             sum_mode;
        logic [PIX_W-1:0] threshold;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/isma_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isma_if
// Valid/ready channels for requests, responses and register setup.
// ----------------------------------------------------------------------------
interface isma_req_if;
    import isma_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0]        coord_x;
    logic [COORD_W-1:0]        coord_y;

    modport source (output valid, command, pixel_value, coord_x, coord_y, input ready);
    modport sink   (input valid, command, pixel_value, coord_x, coord_y, output ready);
endinterface

interface isma_rsp_if;
    import isma_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum_value;

    modport source (output valid, sum_value, input ready);
    modport sink   (input valid, sum_value, output ready);
endinterface

interface isma_cfg_if;
    import isma_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/isma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isma_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module isma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/isma_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isma_cfg_regs
// Register file for mode, threshold and image size.
// ----------------------------------------------------------------------------
module isma_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    isma_cfg_if.sink      setup,
    output isma_pkg::cfg_t cfg
);
    import isma_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign setup.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (setup.valid)
        begin
            case (setup.index)
                REG_SUM_MODE:  cfg_next.sum_mode  = setup.data[0];
                REG_THRESHOLD: cfg_next.threshold = setup.data[PIX_W-1:0];
                REG_WIDTH:     cfg_next.width     = setup.data[DIM_W-1:0];
                REG_HEIGHT:    cfg_next.height    = setup.data[DIM_W-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sum_mode  <= RST_SUM_MODE;
            cfg_reg.threshold <= RST_THRESHOLD;
            cfg_reg.width     <= RST_WIDTH;
            cfg_reg.height    <= RST_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/isma_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isma_unit
// Shared arithmetic: registered multiply-add for addresses and sizes,
// saturating 48-bit accumulate.
// ----------------------------------------------------------------------------
module isma_unit #(
    parameter int A_W = 11,
    parameter int B_W = 11,
    parameter int P_W = 22
) (
    input  wire logic                         clk,
    input  wire logic                         mul_en,
    input  wire logic [A_W-1:0]               mul_a,
    input  wire logic [B_W-1:0]               mul_b,
    input  wire logic [A_W-1:0]               mul_c,
    output      logic [P_W-1:0]               prod,
    input  wire logic signed [isma_pkg::SUM_W-1:0] acc,
    input  wire logic signed [isma_pkg::PIX_W-1:0] inc,
    output      logic signed [isma_pkg::SUM_W-1:0] sum
);
    import isma_pkg::*;

    logic [P_W-1:0]        prod_reg;
    logic signed [SUM_W:0] ext_sum;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= P_W'(mul_a) * P_W'(mul_b) + P_W'(mul_c);
        end
    end

    assign prod = prod_reg;

    always_comb
    begin
        ext_sum = (SUM_W+1)'(acc) + (SUM_W+1)'(inc);
        if (ext_sum[SUM_W] != ext_sum[SUM_W-1])
        begin
            sum = ext_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum = ext_sum[SUM_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/image_stack_masked_accumulator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_stack_masked_accumulator_core
// Per-pixel sum store for a stack of detector images, fed by thresholded
// raster pixels or by disc windows around peak positions.
// ----------------------------------------------------------------------------
// Pixel request: S_PIX (then S_PACC when a threshold-mode pixel is summed).
// Read request: S_RREQ, then S_ROUT to the response register, held until taken.
// Peak request (sum mode only): for each of the 4*R*R window offsets, S_DCHK,
//   then S_DRD and S_DADD if inside disc and image; one sum-store port pair.
// After reset all MAX_WIDTH*MAX_HEIGHT entries of the sum store are cleared,
//   with request.ready low; setup writes are taken throughout.
module image_stack_masked_accumulator_core #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int DISC_RADIUS = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    isma_req_if.sink   request,
    isma_rsp_if.source response,
    isma_cfg_if.sink   setup
);
    import isma_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = WW + HW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(DISC_RADIUS) + 2;
    localparam int SQW   = $clog2(DISC_RADIUS * DISC_RADIUS + 1);
    localparam int CW    = ((DW > COORD_W) ? DW : COORD_W) + 2;
    localparam int R2    = DISC_RADIUS * DISC_RADIUS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PIX, S_PACC, S_DCHK, S_DRD, S_DADD, S_RREQ, S_ROUT
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [AW-1:0]          pidx_reg, pidx_next;
    logic signed [DW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [SQW-1:0]         dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [PIX_W-1:0] pv_reg;
    logic [COORD_W-1:0]      x_reg, y_reg;
    logic                    inrange_reg;
    logic [AW-1:0]           addr_reg;
    logic signed [SUM_W-1:0] out_data_reg;

    cfg_t cfg;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          req_fire;
    logic          req_inrange;

    logic          mul_en;
    logic [HW-1:0] mul_b;
    logic [WW-1:0] mul_c;
    logic [PW-1:0] prod;
    logic signed [PIX_W-1:0] inc;
    logic signed [SUM_W-1:0] sat_sum;

    logic              sum_we, sum_re, buf_we, buf_re, out_load;
    logic [AW-1:0]     sum_waddr, sum_raddr;
    logic [SUM_W-1:0]  sum_wdata, sum_rdata;
    logic [PIX_W-1:0]  buf_rdata;

    logic [AW-1:0]        idx_cur;
    logic [PW-1:0]        idx_inc;
    logic signed [CW-1:0] px, py;
    logic                 in_disc, in_img, disc_last, disc_adv;

    isma_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .setup (setup),
        .cfg   (cfg)
    );

    always_comb
    begin
        if (cfg.width == '0)
            eff_w = WW'(1);
        else if (int'(cfg.width) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(cfg.width);
        if (cfg.height == '0)
            eff_h = HW'(1);
        else if (int'(cfg.height) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(cfg.height);
    end

    assign request.ready = (state_reg == S_IDLE);
    assign req_fire      = request.valid && request.ready;
    assign req_inrange   = (int'(request.coord_x) < int'(eff_w))
                        && (int'(request.coord_y) < int'(eff_h));

    isma_unit #(
        .A_W (WW),
        .B_W (HW),
        .P_W (PW)
    ) u_unit (
        .clk    (clk),
        .mul_en (mul_en),
        .mul_a  (eff_w),
        .mul_b  (mul_b),
        .mul_c  (mul_c),
        .prod   (prod),
        .acc    ($signed(sum_rdata)),
        .inc    (inc),
        .sum    (sat_sum)
    );

    assign inc = (state_reg == S_DADD) ? $signed(buf_rdata) : pv_reg;

    isma_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    isma_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_buf_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (idx_cur),
        .wdata (pv_reg),
        .re    (buf_re),
        .raddr (AW'(prod)),
        .rdata (buf_rdata)
    );

    always_comb
    begin
        idx_cur   = (PW'(pidx_reg) >= prod) ? '0 : pidx_reg;
        idx_inc   = PW'(idx_cur) + PW'(1);
        px        = $signed({{(CW-COORD_W){1'b0}}, x_reg}) + CW'(dx_reg);
        py        = $signed({{(CW-COORD_W){1'b0}}, y_reg}) + CW'(dy_reg);
        in_disc   = (int'(dx2_reg) + int'(dy2_reg)) <= R2;
        in_img    = !px[CW-1] && !py[CW-1]
                 && (int'(px) < int'(eff_w)) && (int'(py) < int'(eff_h));
        disc_last = (dx_reg == DW'(DISC_RADIUS - 1)) && (dy_reg == DW'(DISC_RADIUS - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pidx_next      = pidx_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        out_valid_next = out_valid_reg;
        mul_en         = 1'b0;
        mul_b          = '0;
        mul_c          = '0;
        sum_we         = 1'b0;
        sum_waddr      = addr_reg;
        sum_wdata      = sat_sum;
        sum_re         = 1'b0;
        sum_raddr      = AW'(prod);
        buf_we         = 1'b0;
        buf_re         = 1'b0;
        out_load       = 1'b0;
        disc_adv       = 1'b0;

        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
                sum_wdata = '0;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (request.valid)
                begin
                    case (request.command)
                        CMD_PIXEL:
                        begin
                            mul_en     = 1'b1;
                            mul_b      = eff_h;
                            state_next = S_PIX;
                        end
                        CMD_PEAK:
                        begin
                            if (cfg.sum_mode)
                            begin
                                dx_next    = DW'(-DISC_RADIUS);
                                dy_next    = DW'(-DISC_RADIUS);
                                dx2_next   = SQW'(R2);
                                dy2_next   = SQW'(R2);
                                state_next = S_DCHK;
                            end
                        end
                        CMD_READ:
                        begin
                            mul_en     = 1'b1;
                            mul_b      = HW'(request.coord_y);
                            mul_c      = WW'(request.coord_x);
                            state_next = S_RREQ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX:
            begin
                pidx_next  = (idx_inc >= prod) ? '0 : AW'(idx_inc);
                state_next = S_IDLE;
                if (cfg.sum_mode)
                begin
                    buf_we = 1'b1;
                end
                else if (pv_reg > $signed(cfg.threshold))
                begin
                    sum_re     = 1'b1;
                    sum_raddr  = idx_cur;
                    state_next = S_PACC;
                end
            end
            S_PACC:
            begin
                sum_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_DCHK:
            begin
                if (in_disc && in_img)
                begin
                    mul_en     = 1'b1;
                    mul_b      = HW'(py);
                    mul_c      = WW'(px);
                    state_next = S_DRD;
                end
                else
                begin
                    disc_adv = 1'b1;
                    if (disc_last)
                        state_next = S_IDLE;
                end
            end
            S_DRD:
            begin
                sum_re     = 1'b1;
                buf_re     = 1'b1;
                state_next = S_DADD;
            end
            S_DADD:
            begin
                sum_we     = 1'b1;
                disc_adv   = 1'b1;
                state_next = disc_last ? S_IDLE : S_DCHK;
            end
            S_RREQ:
            begin
                sum_re     = 1'b1;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (disc_adv)
        begin
            if (dy_reg == DW'(DISC_RADIUS - 1))
            begin
                dy_next  = DW'(-DISC_RADIUS);
                dy2_next = SQW'(R2);
                dx_next  = dx_reg + DW'(1);
                dx2_next = SQW'(int'(dx2_reg) + 2 * int'(dx_reg) + 1);
            end
            else
            begin
                dy_next  = dy_reg + DW'(1);
                dy2_next = SQW'(int'(dy2_reg) + 2 * int'(dy_reg) + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pidx_reg      <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dx2_reg       <= '0;
            dy2_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pidx_reg      <= pidx_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dx2_reg       <= dx2_next;
            dy2_reg       <= dy2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pv_reg      <= request.pixel_value;
            x_reg       <= request.coord_x;
            y_reg       <= request.coord_y;
            inrange_reg <= req_inrange;
        end
        if (sum_re)
        begin
            addr_reg <= sum_raddr;
        end
        if (out_load)
        begin
            out_data_reg <= inrange_reg ? $signed(sum_rdata) : '0;
        end
    end

    assign response.valid     = out_valid_reg;
    assign response.sum_value = out_data_reg;

endmodule
`default_nettype wire

// ===== hdl/image_stack_masked_accumulator_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_stack_masked_accumulator_checker
// Port-level properties of the accumulator core, bound to the top level.
// ----------------------------------------------------------------------------
module image_stack_masked_accumulator_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic [isma_pkg::CMD_W-1:0]    req_command,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic signed [isma_pkg::SUM_W-1:0] rsp_sum
);
    import isma_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_sum))
        else $error("response payload changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_PIXEL || req_command == CMD_READ)
        |=> !req_ready)
        else $error("request taken without a busy cycle");

    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared while idle");

endmodule

bind image_stack_masked_accumulator_core image_stack_masked_accumulator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .req_command (request.command),
    .rsp_valid   (response.valid),
    .rsp_ready   (response.ready),
    .rsp_sum     (response.sum_value)
);
`default_nettype wire

// ===== tb/image_stack_masked_accumulator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_stack_masked_accumulator_core_tb
// Self-checking bench for the masked image-stack accumulator. A directed
// table walks reset values, threshold edges, index wrap and clipped discs;
// random phases then mix pixel frames, peaks and reads under changing setup
// and clamped sizes. Every read response is compared with a local sum model
// or a table literal, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module image_stack_masked_accumulator_core_tb;
    import isma_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int DISC_R         = 10;
    localparam int SETTLE_CYCLES  = 4 * DISC_R * DISC_R * 3 + 64;
    localparam int WATCHDOG_LIMIT = 4 * MAX_W * MAX_H;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [PIX_W-1:0] pixel_value;
        logic [COORD_W-1:0]      coord_x;
        logic [COORD_W-1:0]      coord_y;
    } pixel_req_t;

    typedef enum logic {ROW_SETUP, ROW_REQUEST} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DAT_W-1:0]    reg_data;
        pixel_req_t              req;
        bit                      typed;
        logic signed [SUM_W-1:0] sum_lit;
    } plan_row_t;

    typedef enum logic [1:0] {RSP_OPEN, RSP_COIN, RSP_SPARSE, RSP_BURSTY} rsp_style_t;

    logic clk;
    logic rst_n;

    isma_req_if request ();
    isma_rsp_if response ();
    isma_cfg_if setup ();

    image_stack_masked_accumulator_core #(
        .MAX_WIDTH   (MAX_W),
        .MAX_HEIGHT  (MAX_H),
        .DISC_RADIUS (DISC_R)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .setup    (setup)
    );

    // Local copy of the accumulator state and setup
    logic signed [SUM_W-1:0] sum_image [int];
    logic signed [PIX_W-1:0] frame_image [int];
    int unsigned             raster_idx;
    logic                    mode_reg;
    logic [PIX_W-1:0]        thr_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;

    logic signed [SUM_W-1:0] pending_sums [$];
    plan_row_t               directed_plan [$];

    int         fail_count;
    int         live_items;
    int         burst_left;
    bit         sender_eager;
    bit         need_settle;
    int         idle_cycles;
    rsp_style_t rsp_style;
    int         rsp_style_left;
    logic [4:0] rsp_tick;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_w();
        int v;
        v = int'(width_reg);
        if (v < 1) v = 1;
        if (v > MAX_W) v = MAX_W;
        return v;
    endfunction

    function automatic int eff_h();
        int v;
        v = int'(height_reg);
        if (v < 1) v = 1;
        if (v > MAX_H) v = MAX_H;
        return v;
    endfunction

    function automatic longint sum_at(int addr);
        if (sum_image.exists(addr)) return longint'(sum_image[addr]);
        return 0;
    endfunction

    function automatic void add_saturating(int addr, int v);
        longint s;
        s = sum_at(addr) + longint'(v);
        if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
        if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
        sum_image[addr] = s[SUM_W-1:0];
    endfunction

    // Walk the clipped disc; either add buffered pixels or report whether
    // every pixel it touches has been written.
    function automatic bit disc_walk(int cx, int cy, bit apply);
        int w;
        int h;
        int px;
        int py;
        int addr;
        bit ok;
        ok = 1'b1;
        w = eff_w();
        h = eff_h();
        for (int dx = -DISC_R; dx < DISC_R; dx++)
        begin
            for (int dy = -DISC_R; dy < DISC_R; dy++)
            begin
                px = cx + dx;
                py = cy + dy;
                if (dx * dx + dy * dy > DISC_R * DISC_R) continue;
                if (px < 0 || px >= w || py < 0 || py >= h) continue;
                addr = px + w * py;
                if (!frame_image.exists(addr)) ok = 1'b0;
                else if (apply) add_saturating(addr, int'(frame_image[addr]));
            end
        end
        return ok;
    endfunction

    task automatic accumulate_request(input pixel_req_t it, output bit gives,
                                      output logic signed [SUM_W-1:0] sum_out);
        int     w;
        int     h;
        int     size;
        int     pv;
        int     thr;
        longint s;
        w = eff_w();
        h = eff_h();
        size = w * h;
        pv = int'($signed(it.pixel_value));
        thr = int'($signed(thr_reg));
        gives = 1'b0;
        sum_out = '0;
        case (it.command)
            CMD_PIXEL:
            begin
                if (raster_idx >= size) raster_idx = 0;
                if (!mode_reg)
                begin
                    if (pv > thr) add_saturating(raster_idx, pv);
                end
                else
                begin
                    frame_image[raster_idx] = it.pixel_value;
                end
                raster_idx++;
                if (raster_idx >= size) raster_idx = 0;
            end
            CMD_PEAK:
            begin
                if (mode_reg) void'(disc_walk(int'(it.coord_x), int'(it.coord_y), 1'b1));
            end
            CMD_READ:
            begin
                gives = 1'b1;
                if (int'(it.coord_x) < w && int'(it.coord_y) < h)
                begin
                    s = sum_at(int'(it.coord_x) + w * int'(it.coord_y));
                    sum_out = s[SUM_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    function automatic pixel_req_t make_req(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] pv,
                                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        pixel_req_t it;
        it.command = cmd;
        it.pixel_value = pv;
        it.coord_x = x;
        it.coord_y = y;
        return it;
    endfunction

    function automatic void plan_setup(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        plan_row_t row;
        row.kind = ROW_SETUP;
        row.reg_index = idx;
        row.reg_data = data;
        row.req = '0;
        row.typed = 1'b0;
        row.sum_lit = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_req(pixel_req_t it);
        plan_row_t row;
        row.kind = ROW_REQUEST;
        row.reg_index = '0;
        row.reg_data = '0;
        row.req = it;
        row.typed = 1'b0;
        row.sum_lit = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_read_lit(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic signed [SUM_W-1:0] val);
        plan_row_t row;
        row.kind = ROW_REQUEST;
        row.reg_index = '0;
        row.reg_data = '0;
        row.req = make_req(CMD_READ, '0, x, y);
        row.typed = 1'b1;
        row.sum_lit = val;
        directed_plan.push_back(row);
    endfunction

    task automatic send_request(input pixel_req_t it, input bit typed,
                                input logic signed [SUM_W-1:0] sum_lit);
        int                      gap;
        bit                      gives;
        bit                      ignored;
        logic signed [SUM_W-1:0] want;
        if (burst_left == 0)
        begin
            gap = (sender_eager || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                request.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        request.valid       <= 1'b1;
        request.command     <= it.command;
        request.pixel_value <= it.pixel_value;
        request.coord_x     <= it.coord_x;
        request.coord_y     <= it.coord_y;
        do @(posedge clk); while (request.ready !== 1'b1);
        ignored = (it.command == CMD_UNUSED) || (it.command == CMD_PEAK && !mode_reg);
        accumulate_request(it, gives, want);
        if (gives) pending_sums.push_back(typed ? sum_lit : want);
        if (!ignored) live_items++;
        need_settle = 1'b1;
    endtask

    task automatic settle();
        if (need_settle)
        begin
            request.valid <= 1'b0;
            while (pending_sums.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            need_settle = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        setup.valid <= 1'b1;
        setup.index <= idx;
        setup.data  <= data;
        do @(posedge clk); while (setup.ready !== 1'b1);
        case (idx)
            REG_SUM_MODE:  mode_reg = data[0];
            REG_THRESHOLD: thr_reg = data;
            REG_WIDTH:     width_reg = data[DIM_W-1:0];
            REG_HEIGHT:    height_reg = data[DIM_W-1:0];
            default: ;
        endcase
        setup.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int phase_no);
        logic             mode_pick;
        logic [PIX_W-1:0] thr_pick;
        logic [4:0]       junk;
        logic [14:0]      junk_mode;
        int               w_pick;
        int               h_pick;
        int               w;
        int               h;
        int               size;
        int               fill;
        int               n_items;
        int               pick;
        int               addr;
        pixel_req_t       it;
        case (phase_no)
            0:
            begin
                mode_pick = 1'b0; thr_pick = 16'h8000; w_pick = 2047; h_pick = 0;
            end
            1:
            begin
                mode_pick = 1'b1; thr_pick = 16'h7FFF; w_pick = 1;    h_pick = 1024;
            end
            2:
            begin
                mode_pick = 1'b0; thr_pick = 16'h7FFF; w_pick = 1;    h_pick = 1;
            end
            3:
            begin
                mode_pick = 1'b1; thr_pick = 16'h0000; w_pick = 1024; h_pick = 1;
            end
            default:
            begin
                mode_pick = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0) thr_pick = PIX_W'($urandom);
                else thr_pick = PIX_W'($urandom_range(0, 1000) - 500);
                if ($urandom_range(0, 7) == 0)
                begin
                    w_pick = $urandom_range(0, 2047);
                    h_pick = $urandom_range(0, 3);
                end
                else if (mode_pick)
                begin
                    w_pick = $urandom_range(1, 16);
                    h_pick = $urandom_range(1, 16);
                end
                else
                begin
                    w_pick = $urandom_range(1, 32);
                    h_pick = $urandom_range(1, 32);
                end
            end
        endcase
        settle();
        junk_mode = 15'($urandom);
        write_reg(REG_SUM_MODE, {junk_mode, mode_pick});
        write_reg(REG_THRESHOLD, thr_pick);
        junk = 5'($urandom);
        write_reg(REG_WIDTH, {junk, w_pick[DIM_W-1:0]});
        junk = 5'($urandom);
        write_reg(REG_HEIGHT, {junk, h_pick[DIM_W-1:0]});
        w = eff_w();
        h = eff_h();
        size = w * h;
        sender_eager = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        if (mode_reg)
        begin
            fill = (size <= 256) ? size : 64;
            for (int i = 0; i < fill; i++)
                send_request(make_req(CMD_PIXEL, PIX_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom)), 1'b0, '0);
        end
        n_items = $urandom_range(80, 140);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            it = make_req(CMD_PIXEL, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            if ($urandom_range(0, 1) == 0)
                it.pixel_value = PIX_W'(thr_reg + $urandom_range(0, 6) - 3);
            if (pick < 55)
            begin
                it.command = CMD_PIXEL;
            end
            else if (pick < 75)
            begin
                it.command = CMD_READ;
                if (pick < 65)
                begin
                    addr = (raster_idx + size * 40 - $urandom_range(1, 40)) % size;
                    it.coord_x = COORD_W'(addr % w);
                    it.coord_y = COORD_W'(addr / w);
                end
            end
            else if (pick < 92 || pick >= 96)
            begin
                it.command = CMD_PEAK;
                if (pick < 92)
                begin
                    it.coord_x = COORD_W'($urandom_range(0, (w < 40 ? w : 40) + 10));
                    it.coord_y = COORD_W'($urandom_range(0, (h < 40 ? h : 40) + 10));
                end
                // swap for a read when the disc would touch unwritten pixels
                if (mode_reg && !disc_walk(int'(it.coord_x), int'(it.coord_y), 1'b0))
                    it.command = CMD_READ;
            end
            else
            begin
                it.command = CMD_UNUSED;
            end
            send_request(it, 1'b0, '0);
        end
    endtask

    // Response side: stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response.ready <= 1'b0;
            rsp_style      <= RSP_OPEN;
            rsp_style_left <= 0;
            rsp_tick       <= '0;
        end
        else
        begin
            rsp_tick <= rsp_tick + 5'd1;
            if (rsp_style_left == 0)
            begin
                rsp_style      <= rsp_style_t'($urandom_range(0, 3));
                rsp_style_left <= $urandom_range(20, 300);
            end
            else
            begin
                rsp_style_left <= rsp_style_left - 1;
            end
            case (rsp_style)
                RSP_OPEN:   response.ready <= 1'b1;
                RSP_COIN:   response.ready <= 1'($urandom_range(0, 1));
                RSP_SPARSE: response.ready <= ($urandom_range(0, 4) == 0);
                default:    response.ready <= (rsp_tick < 5'd6);
            endcase
        end
    end

    logic signed [SUM_W-1:0] want_sum;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && response.valid === 1'b1 && response.ready === 1'b1)
        begin
            if (pending_sums.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected response: sum_value=%0d", response.sum_value);
            end
            else
            begin
                want_sum = pending_sums.pop_front();
                if (response.sum_value !== want_sum)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("sum_value mismatch: expected %0d, got %0d",
                                 want_sum, response.sum_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request.valid === 1'b1 && request.ready === 1'b1) ||
            (response.valid === 1'b1 && response.ready === 1'b1) ||
            (setup.valid === 1'b1 && setup.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int start_items;
        int phase_no;
        rst_n               <= 1'b0;
        request.valid       <= 1'b0;
        request.command     <= CMD_PIXEL;
        request.pixel_value <= '0;
        request.coord_x     <= '0;
        request.coord_y     <= '0;
        setup.valid         <= 1'b0;
        setup.index         <= REG_SUM_MODE;
        setup.data          <= '0;
        live_items   = 0;
        burst_left   = 0;
        sender_eager = 1'b0;
        need_settle  = 1'b0;
        raster_idx   = 0;
        mode_reg     = RST_SUM_MODE;
        thr_reg      = RST_THRESHOLD;
        width_reg    = RST_WIDTH;
        height_reg   = RST_HEIGHT;

        // reset values, then threshold edges on a 4x4 image
        plan_read_lit(10'd0, 10'd0, 48'sd0);
        plan_read_lit(10'd1023, 10'd1023, 48'sd0);
        plan_setup(REG_SUM_MODE, 16'd0);
        plan_setup(REG_THRESHOLD, 16'd400);
        plan_setup(REG_WIDTH, 16'd4);
        plan_setup(REG_HEIGHT, 16'd4);
        plan_req(make_req(CMD_PIXEL, 16'sh7FFF, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'd400, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'd401, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'sh8000, 10'd0, 10'd0));
        plan_read_lit(10'd0, 10'd0, 48'sd32767);
        plan_read_lit(10'd1, 10'd0, 48'sd0);
        plan_read_lit(10'd2, 10'd0, 48'sd401);
        plan_read_lit(10'd3, 10'd0, 48'sd0);
        plan_read_lit(10'd4, 10'd0, 48'sd0);
        plan_read_lit(10'd0, 10'd4, 48'sd0);
        plan_req(make_req(CMD_UNUSED, 16'hFFFF, 10'd1023, 10'd1023));
        plan_req(make_req(CMD_PEAK, 16'h0000, 10'd0, 10'd0));
        plan_req(make_req(CMD_READ, 16'h0000, 10'd0, 10'd0));
        // peaks on a 2x2 image: stale index restart, wrap, clipped discs
        plan_setup(REG_SUM_MODE, 16'd1);
        plan_setup(REG_WIDTH, 16'd2);
        plan_setup(REG_HEIGHT, 16'd2);
        plan_req(make_req(CMD_PIXEL, 16'sh8000, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'sh7FFF, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'd5, 10'd0, 10'd0));
        plan_req(make_req(CMD_PIXEL, 16'hFFFB, 10'd0, 10'd0));
        plan_req(make_req(CMD_PEAK, 16'h0000, 10'd1, 10'd1));
        plan_req(make_req(CMD_PEAK, 16'h0000, 10'd1023, 10'd1023));
        plan_req(make_req(CMD_READ, 16'h0000, 10'd0, 10'd0));
        plan_req(make_req(CMD_READ, 16'h0000, 10'd1, 10'd1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
        begin
            if (directed_plan[r].kind == ROW_SETUP)
            begin
                settle();
                write_reg(directed_plan[r].reg_index, directed_plan[r].reg_data);
            end
            else
            begin
                send_request(directed_plan[r].req, directed_plan[r].typed,
                             directed_plan[r].sum_lit);
            end
        end

        start_items = live_items;
        phase_no = 0;
        while (live_items - start_items < RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        settle();

        if (fail_count == 0 && pending_sums.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
